// ===== src/calendar_clock_quarter_adjust_assert.svh =====
// Assertion macros for the calendar clock block.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef CALENDAR_CLOCK_QUARTER_ADJUST_ASSERT_SVH
`define CALENDAR_CLOCK_QUARTER_ADJUST_ASSERT_SVH

`ifndef ASSERT_OFF
`define CCQA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CCQA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CCQA_ASSERT_SAME(lbl, ante, cons, msg)
`define CCQA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/ccqa_pkg.sv =====
// Package for the calendar clock: request codes, state encoding, time
// constants and the month length function. No dependencies.
`default_nettype none

package ccqa_pkg;

    typedef enum logic [1:0] {
        REQ_GET     = 2'd0,
        REQ_SET     = 2'd1,
        REQ_QUARTER = 2'd2,
        REQ_PRESET  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_CARRY,
        ST_REPLY
    } t_state;

    typedef struct packed {
        logic accept;   // word taken, latch status
        logic preset;   // refuse with data content error
        logic load;     // load new time
        logic round;    // quarter rounding step
        logic carry;    // hour carry step
    } t_dp_cmd;

    typedef struct packed {
        logic wrap;     // rounding reaches the full hour
    } t_dp_stat;

    // reset time
    localparam logic [15:0] RST_YEAR  = 16'd2002;
    localparam logic [3:0]  RST_MONTH = 4'd12;
    localparam logic [4:0]  RST_DAY   = 5'd4;
    localparam logic [4:0]  RST_HOUR  = 5'd10;
    localparam logic [5:0]  RST_MIN   = 6'd6;
    localparam logic [5:0]  RST_SEC   = 6'd11;
    localparam logic [6:0]  RST_HUND  = 7'd0;

    localparam logic [5:0]  HOURS_PER_DAY   = 6'd24;
    localparam logic [4:0]  MONTHS_PER_YEAR = 5'd12;
    localparam logic [5:0]  SECS_PER_MIN    = 6'd60;
    localparam logic [5:0]  MINS_PER_QTR    = 6'd15;

    // rounding thresholds: secs + 450 crosses a multiple of 900
    localparam logic [11:0] QTR_T1 = 12'd450;
    localparam logic [11:0] QTR_T2 = 12'd1350;
    localparam logic [11:0] QTR_T3 = 12'd2250;
    localparam logic [11:0] QTR_T4 = 12'd3150;

    // y divisible by 25 iff y * inv(25) mod 2^16 <= floor(65535 / 25)
    localparam logic [15:0] INV25     = 16'd23593;
    localparam logic [15:0] DIV25_MAX = 16'd2621;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    function automatic logic [4:0] days_of(input logic [3:0] month, input logic leap);
        logic [4:0] d;
        d = 5'd31;
        if (month >= 4'd1 && month <= 4'd12) begin
            d = MONTH_LEN[month - 4'd1];
            if (month == 4'd2 && leap) begin
                d = 5'd29;
            end
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== src/ccqa_dpath.sv =====
// Datapath of the calendar clock: time registers, quarter rounding and
// hour/day/month/year carry. Uses ccqa_pkg; driven by ccqa_ctrl commands.
`default_nettype none

module ccqa_dpath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ccqa_pkg::t_dp_cmd  i_cmd,
    output ccqa_pkg::t_dp_stat      o_stat,
    input  wire logic [15:0]        i_new_year,
    input  wire logic [3:0]         i_new_month,
    input  wire logic [4:0]         i_new_day,
    input  wire logic [4:0]         i_new_hour,
    input  wire logic [5:0]         i_new_minute,
    input  wire logic [5:0]         i_new_second,
    input  wire logic [6:0]         i_new_hundredths,
    output logic                    o_status,
    output logic [15:0]             o_read_year,
    output logic [3:0]              o_read_month,
    output logic [4:0]              o_read_day,
    output logic [4:0]              o_read_hour,
    output logic [5:0]              o_read_minute,
    output logic [5:0]              o_read_second,
    output logic [6:0]              o_read_hundredths
);
    import ccqa_pkg::*;

    logic [15:0] r_year,   n_year;
    logic [3:0]  r_month,  n_month;
    logic [4:0]  r_day,    n_day;
    logic [4:0]  r_hour,   n_hour;
    logic [5:0]  r_minute, n_minute;
    logic [5:0]  r_second, n_second;
    logic [6:0]  r_hund,   n_hund;
    logic        r_status, n_status;
    logic [15:0] r_y25,    n_y25;

    logic [11:0] secs;
    logic [2:0]  qtr;
    logic [15:0] y_prod;
    logic        leap;
    logic [5:0]  hour_inc;
    logic [5:0]  day_inc;
    logic [4:0]  month_inc;
    logic [4:0]  mlen;

    // minute*60 + second, at most 3843
    assign secs = 12'(r_minute) * 12'(SECS_PER_MIN) + 12'(r_second);
    assign qtr  = 3'(secs >= QTR_T1) + 3'(secs >= QTR_T2)
                + 3'(secs >= QTR_T3) + 3'(secs >= QTR_T4);
    assign o_stat.wrap = (qtr == 3'd4);

    // product mod 2^16
    assign y_prod = r_year * INV25;

    // leap: div by 4, and not by 100 unless by 400 (div by 16 and 25)
    assign leap = (r_year[1:0] == 2'b00)
                && ((r_y25 > DIV25_MAX) || (r_year[3:0] == 4'b0000));

    assign hour_inc  = {1'b0, r_hour} + 6'd1;
    assign day_inc   = {1'b0, r_day} + 6'd1;
    assign month_inc = {1'b0, r_month} + 5'd1;
    assign mlen      = days_of(r_month, leap);

    always_comb begin
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_hund   = r_hund;
        n_status = r_status;
        n_y25    = r_y25;
        if (i_cmd.accept) begin
            n_status = i_cmd.preset;
        end
        if (i_cmd.load) begin
            n_year   = i_new_year;
            n_month  = i_new_month;
            n_day    = i_new_day;
            n_hour   = i_new_hour;
            n_minute = i_new_minute;
            n_second = i_new_second;
            n_hund   = i_new_hundredths;
        end
        if (i_cmd.round) begin
            n_minute = o_stat.wrap ? 6'd0 : 6'(qtr) * MINS_PER_QTR;
            n_second = 6'd0;
            n_hund   = 7'd0;
            n_y25    = y_prod;
        end
        if (i_cmd.carry) begin
            if (hour_inc < HOURS_PER_DAY) begin
                n_hour = hour_inc[4:0];
            end else begin
                n_hour = 5'd0;
                if (day_inc <= {1'b0, mlen}) begin
                    n_day = day_inc[4:0];
                end else begin
                    n_day = 5'd1;
                    if (month_inc <= MONTHS_PER_YEAR) begin
                        n_month = month_inc[3:0];
                    end else begin
                        n_month = 4'd1;
                        n_year  = r_year + 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year   <= RST_YEAR;
            r_month  <= RST_MONTH;
            r_day    <= RST_DAY;
            r_hour   <= RST_HOUR;
            r_minute <= RST_MIN;
            r_second <= RST_SEC;
            r_hund   <= RST_HUND;
            r_status <= 1'b0;
        end else begin
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_hund   <= n_hund;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y25 <= n_y25;
    end

    assign o_status          = r_status;
    assign o_read_year       = r_year;
    assign o_read_month      = r_month;
    assign o_read_day        = r_day;
    assign o_read_hour       = r_hour;
    assign o_read_minute     = r_minute;
    assign o_read_second     = r_second;
    assign o_read_hundredths = r_hund;

endmodule

`default_nettype wire

// ===== src/ccqa_ctrl.sv =====
// Controller of the calendar clock: sequences accept, rounding, carry and
// reply. Uses ccqa_pkg; commands ccqa_dpath.
`default_nettype none

module ccqa_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [1:0]         i_req_type,
    input  wire ccqa_pkg::t_dp_stat i_stat,
    output ccqa_pkg::t_dp_cmd       o_cmd,
    output logic                    o_busy,
    output logic                    o_valid
);
    import ccqa_pkg::*;

    t_state r_state, n_state;
    t_req   req;
    logic   take;

    assign req  = t_req'(i_req_type);
    assign take = i_start && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = (req == REQ_QUARTER) ? ST_ROUND : ST_REPLY;
                end
            end
            ST_ROUND: begin
                n_state = i_stat.wrap ? ST_CARRY : ST_REPLY;
            end
            ST_CARRY: begin
                n_state = ST_REPLY;
            end
            ST_REPLY: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_busy       = 1'b1;
        o_valid      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = take;
                o_cmd.preset = take && (req == REQ_PRESET);
                o_cmd.load   = take && (req == REQ_SET);
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
            end
            ST_CARRY: begin
                o_cmd.carry = 1'b1;
            end
            ST_REPLY: begin
                o_valid = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== src/calendar_clock_quarter_adjust.sv =====
// Top level of the calendar clock with quarter-hour adjust.
// Instantiates ccqa_ctrl and ccqa_dpath; uses ccqa_pkg and the assertion header.
//
// Usage:
//   A request word is taken at a rising edge where start is high and busy is
//   low. i_req_type selects get, set, adjust to quarter or adjust to preset;
//   the i_new_* fields matter only for set.
//   One result word per request: o_valid is high for exactly one cycle and the
//   word is taken at the edge that ends it. The receiver cannot stall, so no
//   result is ever held back.
//   o_status is 1 only for a refused preset adjust; the o_read_* fields hold
//   the stored time after the request.
//   Sequence: get, set and preset go from the accepting edge straight to the
//   reply state. Quarter adjust passes through the rounding state first, and
//   also through the carry state when the rounding reaches the full hour and
//   the hour/day/month/year carry step runs. Busy drops the cycle after the
//   reply, so a new request is taken only after the previous one is answered,
//   once the controller has gone through rounding and carry as needed.
//   Reset (synchronous, active low) loads 2002-12-04 10:06:11.00 and leaves
//   the block idle.
`default_nettype none
`include "calendar_clock_quarter_adjust_assert.svh"

module calendar_clock_quarter_adjust (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [15:0] i_new_year,
    input  wire logic [3:0]  i_new_month,
    input  wire logic [4:0]  i_new_day,
    input  wire logic [4:0]  i_new_hour,
    input  wire logic [5:0]  i_new_minute,
    input  wire logic [5:0]  i_new_second,
    input  wire logic [6:0]  i_new_hundredths,
    output logic             o_valid,
    output logic             o_status,
    output logic [15:0]      o_read_year,
    output logic [3:0]       o_read_month,
    output logic [4:0]       o_read_day,
    output logic [4:0]       o_read_hour,
    output logic [5:0]       o_read_minute,
    output logic [5:0]       o_read_second,
    output logic [6:0]       o_read_hundredths
);
    import ccqa_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    ccqa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_busy     (busy),
        .o_valid    (o_valid)
    );

    ccqa_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .i_new_year        (i_new_year),
        .i_new_month       (i_new_month),
        .i_new_day         (i_new_day),
        .i_new_hour        (i_new_hour),
        .i_new_minute      (i_new_minute),
        .i_new_second      (i_new_second),
        .i_new_hundredths  (i_new_hundredths),
        .o_status          (o_status),
        .o_read_year       (o_read_year),
        .o_read_month      (o_read_month),
        .o_read_day        (o_read_day),
        .o_read_hour       (o_read_hour),
        .o_read_minute     (o_read_minute),
        .o_read_second     (o_read_second),
        .o_read_hundredths (o_read_hundredths)
    );

    `CCQA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
    `CCQA_ASSERT_SAME(a_reply_busy, o_valid, busy, "reply while idle")
    `CCQA_ASSERT_NEXT(a_reply_once, o_valid, !o_valid && !busy, "reply not a single strobe")
    `CCQA_ASSERT_NEXT(a_round_sec, dp_cmd.round, o_read_second == 6'd0, "round left seconds")
    `CCQA_ASSERT_NEXT(a_round_hund, dp_cmd.round, o_read_hundredths == 7'd0, "hundredths kept")

endmodule

`default_nettype wire
